// File: src/qpht_pkg.sv
// Shared types, constants and helper functions for the quadratic probe hash table.
package qpht_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = 5;
  localparam int KEY_W       = 32;
  localparam int COEFF_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINEAR_COEFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SQUARE_COEFF = 2'd2;

  // Reset values of the registers
  localparam logic [SIZE_W-1:0]  TABLE_SIZE_RST = 5'd11;
  localparam logic [COEFF_W-1:0] COEFF_RST      = 16'sd1;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_SEARCH = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD_KEY,
    ST_MOD_C1,
    ST_MOD_C2,
    ST_PROBE,
    ST_FINISH
  } state_t;

  // Request to the shared modulo unit
  typedef struct packed {
    logic             start;
    logic             half;   // operand is 16 bits wide
    logic             neg;    // operand is negative, mag is its magnitude
    logic [KEY_W-1:0] mag;
  } mod_req_t;

  // Answer of the shared modulo unit
  typedef struct packed {
    logic              done;
    logic [SLOT_W-1:0] result;
  } mod_rsp_t;

  // Lookup status of the probed slot
  typedef struct packed {
    logic occ;
    logic hit;
  } probe_st_t;

  // Size in use: zero taken as one, clipped to the table depth
  function automatic logic [SIZE_W-1:0] active_size(input logic [SIZE_W-1:0] ts);
    logic [SIZE_W-1:0] m;
    begin
      if (ts == '0) begin
        m = SIZE_W'(1);
      end else if (ts > SIZE_W'(TABLE_DEPTH)) begin
        m = SIZE_W'(TABLE_DEPTH);
      end else begin
        m = ts;
      end
      return m;
    end
  endfunction

  // (a + b) mod m for a, b already below m
  function automatic logic [SLOT_W-1:0] add_mod(input logic [SLOT_W-1:0] a,
                                                 input logic [SLOT_W-1:0] b,
                                                 input logic [SIZE_W-1:0] m);
    logic [SIZE_W-1:0] s;
    begin
      s = SIZE_W'(a) + SIZE_W'(b);
      if (s >= m) begin
        s = s - m;
      end
      return s[SLOT_W-1:0];
    end
  endfunction

endpackage

// File: src/qpht_req_if.sv
// Request channel: operation and key.
interface qpht_req_if;
  logic                      valid;
  logic                      ready;
  qpht_pkg::action_t         action;
  logic signed [qpht_pkg::KEY_W-1:0] key;

  modport source (output valid, output action, output key, input ready);
  modport sink   (input valid, input action, input key, output ready);
endinterface

// File: src/qpht_rsp_if.sv
// Response channel: slot and success flag.
interface qpht_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [qpht_pkg::SLOT_W-1:0] slot;
  logic                        ok;

  modport source (output valid, output slot, output ok, input ready);
  modport sink   (input valid, input slot, input ok, output ready);
endinterface

// File: src/quadratic_probe_hash_table.sv
// Top level: quadratic probe hash table with sequencer and configuration registers.
//
// Use: the req channel carries one item (action 0 insert, 1 search, and a
// signed 32-bit key). The rsp channel returns one item per request: the slot
// and ok. ok is 0 on insert when none of the m probed slots is free or for a
// missing key on search, and slot is 0 then. Registers table_size,
// linear_coeff and square_coeff are written on the cfg port (cfg_we,
// cfg_index, cfg_data); the user must write them only while idle, as the
// block itself does not enforce it.
// Timing: one request is worked on at a time and req.ready is low meanwhile.
// The shared modulo unit reduces the key and both coefficients by the table
// size, two bits per cycle; then one slot is probed per cycle, up to m probes.
// Reset clears all occupied flags and loads the register defaults (size 11,
// both coefficients 1); req.ready is low while rst is high and the block is
// ready right after reset.
// A stalled receiver: the response sits in an output register; the next
// request is accepted meanwhile, but its response waits until the register
// has been taken.
module quadratic_probe_hash_table (
  input  logic                             clk,
  input  logic                             rst,
  qpht_req_if.sink                         req,
  qpht_rsp_if.source                       rsp,
  input  logic                             cfg_we,
  input  logic [qpht_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [qpht_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import qpht_pkg::*;

  state_t state, state_next;

  // Configuration registers
  logic [SIZE_W-1:0]  table_size;
  logic [COEFF_W-1:0] linear_coeff;
  logic [COEFF_W-1:0] square_coeff;

  // Item registers
  action_t           act;
  logic [KEY_W-1:0]  key;
  logic [SIZE_W-1:0] m;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] c1m;
  logic [SLOT_W-1:0] step;
  logic [SLOT_W-1:0] step_inc;
  logic [SIZE_W-1:0] probe_cnt;
  logic [SLOT_W-1:0] res_slot;
  logic              res_ok;

  // Output register
  logic              out_valid;
  logic [SLOT_W-1:0] out_slot;
  logic              out_ok;

  mod_req_t  mreq;
  mod_rsp_t  mrsp;
  probe_st_t pst;

  logic accept;
  logic wr_en;
  logic probe_end;
  logic probe_ok;
  logic load_out;
  logic [SIZE_W-1:0] c2x2;

  assign accept = req.valid && req.ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size   <= TABLE_SIZE_RST;
      linear_coeff <= COEFF_RST;
      square_coeff <= COEFF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TABLE_SIZE:   table_size   <= cfg_data[SIZE_W-1:0];
        REG_LINEAR_COEFF: linear_coeff <= cfg_data[COEFF_W-1:0];
        REG_SQUARE_COEFF: square_coeff <= cfg_data[COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  qpht_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .m   (m),
    .req (mreq),
    .rsp (mrsp)
  );

  qpht_store u_store (
    .clk    (clk),
    .rst    (rst),
    .addr   (slot),
    .wr_en  (wr_en),
    .wr_key (key),
    .st     (pst)
  );

  // 2*c2 mod m from the reduced c2
  always_comb begin
    c2x2 = {mrsp.result, 1'b0};
    if (c2x2 >= m) begin
      c2x2 = c2x2 - m;
    end
  end

  // Sequencer: next state and control
  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    mreq       = '0;
    wr_en      = 1'b0;
    probe_end  = 1'b0;
    probe_ok   = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        // no item is taken while reset is held
        req.ready = !rst;
        if (req.valid && !rst) begin
          mreq.start = 1'b1;
          mreq.neg   = req.key[KEY_W-1];
          mreq.mag   = req.key[KEY_W-1] ? (~req.key + KEY_W'(1)) : req.key;
          state_next = ST_MOD_KEY;
        end
      end
      ST_MOD_KEY: begin
        if (mrsp.done) begin
          mreq.start = 1'b1;
          mreq.half  = 1'b1;
          mreq.neg   = linear_coeff[COEFF_W-1];
          mreq.mag   = KEY_W'(linear_coeff[COEFF_W-1] ?
                              (~linear_coeff + COEFF_W'(1)) : linear_coeff);
          state_next = ST_MOD_C1;
        end
      end
      ST_MOD_C1: begin
        if (mrsp.done) begin
          mreq.start = 1'b1;
          mreq.half  = 1'b1;
          mreq.neg   = square_coeff[COEFF_W-1];
          mreq.mag   = KEY_W'(square_coeff[COEFF_W-1] ?
                              (~square_coeff + COEFF_W'(1)) : square_coeff);
          state_next = ST_MOD_C2;
        end
      end
      ST_MOD_C2: begin
        if (mrsp.done) begin
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (act == ACT_INSERT) begin
          if (!pst.occ) begin
            wr_en     = 1'b1;
            probe_end = 1'b1;
            probe_ok  = 1'b1;
          end
        end else begin
          if (!pst.occ) begin
            probe_end = 1'b1;
          end else if (pst.hit) begin
            probe_end = 1'b1;
            probe_ok  = 1'b1;
          end
        end
        if (probe_cnt == m - SIZE_W'(1)) begin
          probe_end = 1'b1;
        end
        if (probe_end) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      act <= req.action;
      key <= req.key;
      m   <= active_size(table_size);
    end
    case (state)
      ST_MOD_KEY: begin
        if (mrsp.done) begin
          slot <= mrsp.result;
        end
      end
      ST_MOD_C1: begin
        if (mrsp.done) begin
          c1m <= mrsp.result;
        end
      end
      ST_MOD_C2: begin
        if (mrsp.done) begin
          // step for probe 0 to 1 is c1 + c2; it grows by 2*c2 per probe
          step      <= add_mod(c1m, mrsp.result, m);
          step_inc  <= c2x2[SLOT_W-1:0];
          probe_cnt <= '0;
        end
      end
      ST_PROBE: begin
        if (probe_end) begin
          res_ok   <= probe_ok;
          res_slot <= probe_ok ? slot : '0;
        end else begin
          slot      <= add_mod(slot, step, m);
          step      <= add_mod(step, step_inc, m);
          probe_cnt <= probe_cnt + SIZE_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_slot <= res_slot;
      out_ok   <= res_ok;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.slot  = out_slot;
  assign rsp.ok    = out_ok;

endmodule

// File: src/qpht_mod_unit.sv
// Shared modulo unit: signed operand mod m, two magnitude bits per cycle.
module qpht_mod_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [qpht_pkg::SIZE_W-1:0]   m,
  input  qpht_pkg::mod_req_t            req,
  output qpht_pkg::mod_rsp_t            rsp
);
  import qpht_pkg::*;

  logic              busy;
  logic              done;
  logic              neg;
  logic [3:0]        cnt;
  logic [KEY_W-1:0]  sh;
  logic [SLOT_W-1:0] r;

  logic [SIZE_W:0]   t;
  logic [SIZE_W:0]   m1;
  logic [SIZE_W:0]   m2;
  logic [SIZE_W:0]   m3;
  logic [SIZE_W:0]   t_red;
  logic [SIZE_W-1:0] neg_res;

  // One step: r = (4r + next two bits) mod m, by one subtract of m, 2m or 3m
  always_comb begin
    m1 = {1'b0, m};
    m2 = {m, 1'b0};
    m3 = m2 + m1;
    t  = {r, 2'b00} + (SIZE_W+1)'(sh[KEY_W-1 -: 2]);
    if (t >= m3) begin
      t_red = t - m3;
    end else if (t >= m2) begin
      t_red = t - m2;
    end else if (t >= m1) begin
      t_red = t - m1;
    end else begin
      t_red = t;
    end
  end

  // Control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sh  <= req.half ? {req.mag[COEFF_W-1:0], {(KEY_W-COEFF_W){1'b0}}} : req.mag;
      cnt <= req.half ? 4'd7 : 4'd15;
      r   <= '0;
      neg <= req.neg;
    end else if (busy) begin
      sh  <= sh << 2;
      cnt <= cnt - 4'd1;
      r   <= t_red[SLOT_W-1:0];
    end
  end

  // Negative operand: a nonzero remainder folds to m - r
  assign neg_res    = m - SIZE_W'(r);
  assign rsp.done   = done;
  assign rsp.result = (neg && r != '0) ? neg_res[SLOT_W-1:0] : r;

endmodule

// File: src/qpht_store.sv
// Key store with occupied flags and key compare at the probed slot.
module qpht_store (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [qpht_pkg::SLOT_W-1:0]   addr,
  input  logic                          wr_en,
  input  logic [qpht_pkg::KEY_W-1:0]    wr_key,
  output qpht_pkg::probe_st_t           st
);
  import qpht_pkg::*;

  logic [KEY_W-1:0]       keys [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] occ;

  // Occupied flags: cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (wr_en) begin
      occ[addr] <= 1'b1;
    end
  end

  // Keys: no reset, only read when occupied
  always_ff @(posedge clk) begin
    if (wr_en) begin
      keys[addr] <= wr_key;
    end
  end

  assign st.occ = occ[addr];
  assign st.hit = occ[addr] && (keys[addr] == wr_key);

endmodule
